FILE: sv/voxel_face_culling_mesher_defines.svh
// Assertion macros for the voxel face culling mesher.
`ifndef VOXEL_FACE_CULLING_MESHER_DEFINES_SVH
`define VOXEL_FACE_CULLING_MESHER_DEFINES_SVH

`ifndef SYNTHESIS

// Same-cycle implication, disabled while reset is low.
`define VFCM_ASSERT_IMP(name, clk, rstn, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is low.
`define VFCM_ASSERT_NXT(name, clk, rstn, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error(msg);

`else

`define VFCM_ASSERT_IMP(name, clk, rstn, ante, cons, msg)

`define VFCM_ASSERT_NXT(name, clk, rstn, ante, cons, msg)

`endif

`endif

FILE: sv/vfcm_pkg.sv
// Shared types and constants of the voxel face culling mesher.
`timescale 1ns / 1ps

package vfcm_pkg;

    // Field widths
    localparam int COORD_W  = 4;
    localparam int NB_W     = COORD_W + 1;
    localparam int CODE_W   = 8;
    localparam int KIND_W   = 2;
    localparam int DIR_W    = 3;
    localparam int TILE_F_W = 4;
    localparam int COUNT_W  = 15;
    localparam int VERT_W   = COUNT_W + 2;
    localparam int NUM_DIRS = 6;
    localparam int CFG_IDX_W = 1;

    // Item kinds
    localparam logic [KIND_W-1:0] KIND_WRITE = 2'd0;
    localparam logic [KIND_W-1:0] KIND_BEGIN = 2'd1;
    localparam logic [KIND_W-1:0] KIND_MESH  = 2'd2;

    // Face directions, in the order they are tried
    localparam logic [DIR_W-1:0] DIR_TOP    = 3'd0;
    localparam logic [DIR_W-1:0] DIR_BOTTOM = 3'd1;
    localparam logic [DIR_W-1:0] DIR_LEFT   = 3'd2;
    localparam logic [DIR_W-1:0] DIR_RIGHT  = 3'd3;
    localparam logic [DIR_W-1:0] DIR_FRONT  = 3'd4;
    localparam logic [DIR_W-1:0] DIR_BACK   = 3'd5;

    // Configuration register indexes and reset values
    localparam logic [CFG_IDX_W-1:0] CFG_AIR_CODE   = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_GRASS_CODE = 1'd1;
    localparam logic [CODE_W-1:0]    AIR_CODE_RESET   = 8'd0;
    localparam logic [CODE_W-1:0]    GRASS_CODE_RESET = 8'd1;

    // Grass atlas tiles
    localparam logic [CODE_W-1:0] TILE_GRASS_TOP    = 8'd0;
    localparam logic [CODE_W-1:0] TILE_GRASS_BOTTOM = 8'd2;
    localparam logic [CODE_W-1:0] TILE_GRASS_SIDE   = 8'd15;

    // Fraction bits of the reciprocal used for the tile row
    localparam int RECIP_SH = 16;

    typedef struct packed {
        logic             clear;
        logic             load_item;
        logic             count_clear;
        logic             write;
        logic             rd_nb;
        logic [DIR_W-1:0] rd_dir;
        logic             load_type;
        logic             capture;
        logic [DIR_W-1:0] cap_dir;
        logic             emit;
    } vfcm_cmd_t;

    typedef struct packed {
        logic clear_last;
        logic center_in;
        logic center_air;
        logic mask_empty;
        logic last_sel;
    } vfcm_status_t;

endpackage

FILE: sv/vfcm_dp.sv
// Datapath of the mesher: block store, neighbor addressing, tile math, face output register.
`timescale 1ns / 1ps

module vfcm_dp #(
    parameter int CHUNK_EDGE          = 16,
    parameter int ATLAS_TILES_PER_ROW = 16
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  vfcm_pkg::vfcm_cmd_t               cmd,
    output vfcm_pkg::vfcm_status_t            status,
    input  logic                              cfg_wen,
    input  logic [vfcm_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [vfcm_pkg::CODE_W-1:0]       cfg_wdata,
    input  logic [vfcm_pkg::COORD_W-1:0]      s_block_x,
    input  logic [vfcm_pkg::COORD_W-1:0]      s_block_y,
    input  logic [vfcm_pkg::COORD_W-1:0]      s_block_z,
    input  logic [vfcm_pkg::CODE_W-1:0]       s_block_code,
    output logic [vfcm_pkg::COORD_W-1:0]      m_face_x,
    output logic [vfcm_pkg::COORD_W-1:0]      m_face_y,
    output logic [vfcm_pkg::COORD_W-1:0]      m_face_z,
    output logic [vfcm_pkg::DIR_W-1:0]        m_face_direction,
    output logic [vfcm_pkg::TILE_F_W-1:0]     m_tile_column,
    output logic [vfcm_pkg::TILE_F_W-1:0]     m_tile_row,
    output logic [vfcm_pkg::VERT_W-1:0]       m_first_vertex,
    output logic                              m_last_face
);
    import vfcm_pkg::*;

    localparam int DEPTH   = CHUNK_EDGE * CHUNK_EDGE * CHUNK_EDGE;
    localparam int ADDR_W  = $clog2(DEPTH);
    localparam int EDGE_SQ = CHUNK_EDGE * CHUNK_EDGE;
    localparam int RECIP   = (2 ** RECIP_SH + ATLAS_TILES_PER_ROW - 1) / ATLAS_TILES_PER_ROW;
    localparam int PROD_W  = RECIP_SH + CODE_W;

    localparam logic [TILE_F_W-1:0] GT_COL =
        TILE_F_W'(TILE_GRASS_TOP % ATLAS_TILES_PER_ROW);
    localparam logic [TILE_F_W-1:0] GT_ROW =
        TILE_F_W'(TILE_GRASS_TOP / ATLAS_TILES_PER_ROW);
    localparam logic [TILE_F_W-1:0] GB_COL =
        TILE_F_W'(TILE_GRASS_BOTTOM % ATLAS_TILES_PER_ROW);
    localparam logic [TILE_F_W-1:0] GB_ROW =
        TILE_F_W'(TILE_GRASS_BOTTOM / ATLAS_TILES_PER_ROW);
    localparam logic [TILE_F_W-1:0] GS_COL =
        TILE_F_W'(TILE_GRASS_SIDE % ATLAS_TILES_PER_ROW);
    localparam logic [TILE_F_W-1:0] GS_ROW =
        TILE_F_W'(TILE_GRASS_SIDE / ATLAS_TILES_PER_ROW);

    logic [CODE_W-1:0]   mem [DEPTH];

    logic [CODE_W-1:0]   air_code_reg, grass_code_reg;
    logic [COORD_W-1:0]  x_reg, y_reg, z_reg;
    logic [CODE_W-1:0]   code_reg;
    logic [ADDR_W-1:0]   clr_addr_reg;
    logic [CODE_W-1:0]   rd_data_reg;
    logic                nb_oob_reg;
    logic [CODE_W-1:0]   tm1_reg, q_reg;
    logic                is_grass_reg;
    logic [NUM_DIRS-1:0] mask_reg;
    logic [COUNT_W-1:0]  count_reg;

    logic [COORD_W-1:0]  face_x_reg, face_y_reg, face_z_reg;
    logic [DIR_W-1:0]    face_dir_reg;
    logic [TILE_F_W-1:0] col_reg, row_reg;
    logic [VERT_W-1:0]   vert_reg;
    logic                last_reg;

    logic [NB_W-1:0]     nx, ny, nz;
    logic                nb_under, nb_in, center_in;
    logic [ADDR_W-1:0]   center_addr, nb_addr, mem_addr;
    logic                mem_we;
    logic [CODE_W-1:0]   mem_wdata;
    logic                open_side;
    logic [CODE_W-1:0]   tm1;
    logic [PROD_W-1:0]   prod;
    logic [CODE_W-1:0]   qm, rem;
    logic [DIR_W-1:0]    sel_dir;
    logic [NUM_DIRS-1:0] sel_onehot, rest_mask;
    logic [TILE_F_W-1:0] col, row;

    // Configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            air_code_reg   <= AIR_CODE_RESET;
            grass_code_reg <= GRASS_CODE_RESET;
        end else if (cfg_wen) begin
            case (cfg_index)
                CFG_AIR_CODE:   air_code_reg   <= cfg_wdata;
                CFG_GRASS_CODE: grass_code_reg <= cfg_wdata;
                default: ;
            endcase
        end
    end

    // Center address and chunk bounds
    assign center_in = (int'(x_reg) < CHUNK_EDGE) && (int'(y_reg) < CHUNK_EDGE)
                    && (int'(z_reg) < CHUNK_EDGE);
    assign center_addr = ADDR_W'(int'(x_reg) * EDGE_SQ + int'(y_reg) * CHUNK_EDGE
                                 + int'(z_reg));

    // Step to the neighbor in the requested direction
    always_comb begin
        nx       = {1'b0, x_reg};
        ny       = {1'b0, y_reg};
        nz       = {1'b0, z_reg};
        nb_under = 1'b0;
        case (cmd.rd_dir)
            DIR_TOP:    ny = {1'b0, y_reg} + NB_W'(1);
            DIR_BOTTOM: begin
                ny       = {1'b0, y_reg} - NB_W'(1);
                nb_under = (y_reg == '0);
            end
            DIR_LEFT:   begin
                nx       = {1'b0, x_reg} - NB_W'(1);
                nb_under = (x_reg == '0);
            end
            DIR_RIGHT:  nx = {1'b0, x_reg} + NB_W'(1);
            DIR_FRONT:  nz = {1'b0, z_reg} + NB_W'(1);
            DIR_BACK:   begin
                nz       = {1'b0, z_reg} - NB_W'(1);
                nb_under = (z_reg == '0);
            end
            default: ;
        endcase
    end

    assign nb_in = !nb_under && (int'(nx) < CHUNK_EDGE) && (int'(ny) < CHUNK_EDGE)
                && (int'(nz) < CHUNK_EDGE);
    assign nb_addr = ADDR_W'(int'(nx) * EDGE_SQ + int'(ny) * CHUNK_EDGE + int'(nz));

    // Select the single store access of this cycle
    always_comb begin
        mem_we    = 1'b0;
        mem_addr  = center_addr;
        mem_wdata = code_reg;
        if (cmd.clear) begin
            mem_we    = 1'b1;
            mem_addr  = clr_addr_reg;
            mem_wdata = '0;
        end else if (cmd.write) begin
            mem_we = center_in;
        end else if (cmd.rd_nb) begin
            mem_addr = nb_addr;
        end
    end

    // Block store, read data registered
    always_ff @(posedge aclk) begin
        if (mem_we) begin
            mem[mem_addr] <= mem_wdata;
        end
        rd_data_reg <= mem[mem_addr];
        nb_oob_reg  <= !nb_in;
    end

    // Advance the clearing pass
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            clr_addr_reg <= '0;
        end else if (cmd.clear && !status.clear_last) begin
            clr_addr_reg <= clr_addr_reg + ADDR_W'(1);
        end
    end

    // Hold the accepted item
    always_ff @(posedge aclk) begin
        if (cmd.load_item) begin
            x_reg    <= s_block_x;
            y_reg    <= s_block_y;
            z_reg    <= s_block_z;
            code_reg <= s_block_code;
        end
    end

    // Tile index: type minus one, row by reciprocal multiply
    assign tm1  = rd_data_reg - CODE_W'(1);
    assign prod = PROD_W'(tm1) * PROD_W'(RECIP);

    always_ff @(posedge aclk) begin
        if (cmd.load_type) begin
            tm1_reg      <= tm1;
            q_reg        <= prod[RECIP_SH +: CODE_W];
            is_grass_reg <= (rd_data_reg == grass_code_reg);
        end
    end

    assign qm  = CODE_W'(PROD_W'(q_reg) * PROD_W'(ATLAS_TILES_PER_ROW));
    assign rem = tm1_reg - qm;

    // Open sides and emission order
    assign open_side = nb_oob_reg || (rd_data_reg == air_code_reg);

    always_comb begin
        sel_dir = DIR_TOP;
        for (int i = NUM_DIRS - 1; i >= 0; i--) begin
            if (mask_reg[i]) begin
                sel_dir = DIR_W'(i);
            end
        end
    end

    assign sel_onehot = NUM_DIRS'(1) << sel_dir;
    assign rest_mask  = mask_reg & ~sel_onehot;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mask_reg <= '0;
        end else if (cmd.capture) begin
            mask_reg[cmd.cap_dir] <= open_side;
        end else if (cmd.emit) begin
            mask_reg <= rest_mask;
        end
    end

    // Pick the atlas tile of the face
    always_comb begin
        col = rem[TILE_F_W-1:0];
        row = q_reg[TILE_F_W-1:0];
        if (is_grass_reg) begin
            case (sel_dir)
                DIR_TOP:    begin col = GT_COL; row = GT_ROW; end
                DIR_BOTTOM: begin col = GB_COL; row = GB_ROW; end
                default:    begin col = GS_COL; row = GS_ROW; end
            endcase
        end
    end

    // Face counter
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg <= '0;
        end else if (cmd.count_clear) begin
            count_reg <= '0;
        end else if (cmd.emit) begin
            count_reg <= count_reg + COUNT_W'(1);
        end
    end

    // Face output register
    always_ff @(posedge aclk) begin
        if (cmd.emit) begin
            face_x_reg   <= x_reg;
            face_y_reg   <= y_reg;
            face_z_reg   <= z_reg;
            face_dir_reg <= sel_dir;
            col_reg      <= col;
            row_reg      <= row;
            vert_reg     <= {count_reg, 2'b00};
            last_reg     <= (rest_mask == '0);
        end
    end

    assign m_face_x         = face_x_reg;
    assign m_face_y         = face_y_reg;
    assign m_face_z         = face_z_reg;
    assign m_face_direction = face_dir_reg;
    assign m_tile_column    = col_reg;
    assign m_tile_row       = row_reg;
    assign m_first_vertex   = vert_reg;
    assign m_last_face      = last_reg;

    assign status.clear_last = (clr_addr_reg == ADDR_W'(DEPTH - 1));
    assign status.center_in  = center_in;
    assign status.center_air = (rd_data_reg == air_code_reg);
    assign status.mask_empty = (mask_reg == '0);
    assign status.last_sel   = (rest_mask == '0);

endmodule

FILE: sv/vfcm_ctrl.sv
// Controller of the mesher: sequences store clear, writes, neighbor reads and face output.
`timescale 1ns / 1ps

module vfcm_ctrl (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           s_valid,
    output logic                           s_ready,
    input  logic [vfcm_pkg::KIND_W-1:0]    s_kind,
    output logic                           m_valid,
    input  logic                           m_ready,
    output vfcm_pkg::vfcm_cmd_t            cmd,
    input  vfcm_pkg::vfcm_status_t         status
);
    import vfcm_pkg::*;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_WRITE,
        ST_READ_CENTER,
        ST_CHECK_TYPE,
        ST_NEIGHBOR,
        ST_EMIT
    } state_t;

    state_t           state_reg, state_next;
    logic [DIR_W-1:0] dir_reg, dir_next;
    logic             m_valid_reg, m_valid_next;
    logic             out_free;

    assign out_free = !m_valid_reg || m_ready;

    // Next state and commands
    always_comb begin
        state_next   = state_reg;
        dir_next     = dir_reg;
        m_valid_next = m_valid_reg;
        cmd          = '0;
        // drop the face once its transfer completes
        if (m_ready) begin
            m_valid_next = 1'b0;
        end
        case (state_reg)
            ST_CLEAR: begin
                cmd.clear = 1'b1;
                if (status.clear_last) begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (s_valid) begin
                    cmd.load_item = 1'b1;
                    case (s_kind)
                        KIND_WRITE: state_next = ST_WRITE;
                        KIND_BEGIN: cmd.count_clear = 1'b1;
                        KIND_MESH:  state_next = ST_READ_CENTER;
                        default: ;
                    endcase
                end
            end
            ST_WRITE: begin
                cmd.write  = 1'b1;
                state_next = ST_IDLE;
            end
            ST_READ_CENTER: begin
                // the store reads the center address unless another access is asked for
                if (status.center_in) begin
                    state_next = ST_CHECK_TYPE;
                end else begin
                    state_next = ST_IDLE;
                end
            end
            ST_CHECK_TYPE: begin
                cmd.load_type = 1'b1;
                if (status.center_air) begin
                    state_next = ST_IDLE;
                end else begin
                    cmd.rd_nb  = 1'b1;
                    cmd.rd_dir = DIR_TOP;
                    dir_next   = DIR_TOP;
                    state_next = ST_NEIGHBOR;
                end
            end
            ST_NEIGHBOR: begin
                cmd.capture = 1'b1;
                cmd.cap_dir = dir_reg;
                if (dir_reg == DIR_BACK) begin
                    state_next = ST_EMIT;
                end else begin
                    cmd.rd_nb  = 1'b1;
                    cmd.rd_dir = dir_reg + DIR_W'(1);
                    dir_next   = dir_reg + DIR_W'(1);
                end
            end
            ST_EMIT: begin
                if (status.mask_empty) begin
                    state_next = ST_IDLE;
                end else if (out_free) begin
                    cmd.emit     = 1'b1;
                    m_valid_next = 1'b1;
                    if (status.last_sel) begin
                        state_next = ST_IDLE;
                    end
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // Hold state and registered outputs
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_CLEAR;
            dir_reg     <= DIR_TOP;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            dir_reg     <= dir_next;
            m_valid_reg <= m_valid_next;
        end
    end

    assign s_ready = (state_reg == ST_IDLE);
    assign m_valid = m_valid_reg;

endmodule

FILE: sv/voxel_face_culling_mesher.sv
// Top level of the voxel face culling mesher: controller, datapath and checks.
// Six neighbor reads of the single-port store pace a mesh item, then one face per ready cycle.
// Reset clears the store to 0, taking no item until done; registers reset to air 0 and
//   grass 1, face count to 0.
`timescale 1ns / 1ps
`include "voxel_face_culling_mesher_defines.svh"

module voxel_face_culling_mesher #(
    parameter int CHUNK_EDGE          = 16,
    parameter int ATLAS_TILES_PER_ROW = 16
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              cfg_wen,
    input  logic [vfcm_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [vfcm_pkg::CODE_W-1:0]       cfg_wdata,
    input  logic                              s_valid,
    output logic                              s_ready,
    input  logic [vfcm_pkg::KIND_W-1:0]       s_kind,
    input  logic [vfcm_pkg::COORD_W-1:0]      s_block_x,
    input  logic [vfcm_pkg::COORD_W-1:0]      s_block_y,
    input  logic [vfcm_pkg::COORD_W-1:0]      s_block_z,
    input  logic [vfcm_pkg::CODE_W-1:0]       s_block_code,
    output logic                              m_valid,
    input  logic                              m_ready,
    output logic [vfcm_pkg::COORD_W-1:0]      m_face_x,
    output logic [vfcm_pkg::COORD_W-1:0]      m_face_y,
    output logic [vfcm_pkg::COORD_W-1:0]      m_face_z,
    output logic [vfcm_pkg::DIR_W-1:0]        m_face_direction,
    output logic [vfcm_pkg::TILE_F_W-1:0]     m_tile_column,
    output logic [vfcm_pkg::TILE_F_W-1:0]     m_tile_row,
    output logic [vfcm_pkg::VERT_W-1:0]       m_first_vertex,
    output logic                              m_last_face
);
    import vfcm_pkg::*;

    vfcm_cmd_t    cmd;
    vfcm_status_t status;

    // Sequencer
    vfcm_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_kind  (s_kind),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .cmd     (cmd),
        .status  (status)
    );

    // Store and face datapath
    vfcm_dp #(
        .CHUNK_EDGE          (CHUNK_EDGE),
        .ATLAS_TILES_PER_ROW (ATLAS_TILES_PER_ROW)
    ) u_dp (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .cmd              (cmd),
        .status           (status),
        .cfg_wen          (cfg_wen),
        .cfg_index        (cfg_index),
        .cfg_wdata        (cfg_wdata),
        .s_block_x        (s_block_x),
        .s_block_y        (s_block_y),
        .s_block_z        (s_block_z),
        .s_block_code     (s_block_code),
        .m_face_x         (m_face_x),
        .m_face_y         (m_face_y),
        .m_face_z         (m_face_z),
        .m_face_direction (m_face_direction),
        .m_tile_column    (m_tile_column),
        .m_tile_row       (m_tile_row),
        .m_first_vertex   (m_first_vertex),
        .m_last_face      (m_last_face)
    );

    // A face is loaded only when the output register is free
    `VFCM_ASSERT_IMP(a_emit_free, aclk, aresetn, cmd.emit, (!m_valid || m_ready), "emit over a waiting face")
    // A face is loaded only while open sides remain
    `VFCM_ASSERT_IMP(a_emit_mask, aclk, aresetn, cmd.emit, !status.mask_empty, "emit with no open side")
    // No item is taken during the clearing pass
    `VFCM_ASSERT_IMP(a_clear_busy, aclk, aresetn, cmd.clear, !s_ready, "input ready while clearing")
    // An air block ends its mesh item at once
    `VFCM_ASSERT_NXT(a_air_done, aclk, aresetn, (cmd.load_type && status.center_air), s_ready, "air block not dropped")

endmodule
